// File: design/rpsw_pkg.sv
package rpsw_pkg;

    // Default sizing
    localparam int DEF_MAX_WIDTH    = 1024;
    localparam int DEF_MAX_HEIGHT   = 4096;
    localparam int DEF_MAX_DISTANCE = 16;

    // Field widths
    localparam int CHAN_W   = 8;
    localparam int PIX_W    = 3 * CHAN_W;
    localparam int WEIGHT_W = 6;
    localparam int COL_W    = 10;
    localparam int ROW_W    = 12;
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 32;

    // Register file
    localparam int ADDR_W        = 4;
    localparam int CFG_W         = 32;
    localparam int CFG_WIDTH_W   = 11;
    localparam int CFG_HEIGHT_W  = 13;
    localparam int CFG_DIST_W    = 5;

    typedef enum logic [1:0] {
        REG_WIDTH     = 2'd0,
        REG_HEIGHT    = 2'd1,
        REG_DISTANCE  = 2'd2,
        REG_DIRECTION = 2'd3
    } reg_idx_t;

    localparam logic [CFG_WIDTH_W-1:0]  RST_WIDTH    = 11'd640;
    localparam logic [CFG_HEIGHT_W-1:0] RST_HEIGHT   = 13'd480;
    localparam logic [CFG_DIST_W-1:0]   RST_DISTANCE = 5'd1;
    localparam logic                    DIR_VERTICAL   = 1'b0;
    localparam logic                    DIR_HORIZONTAL = 1'b1;

    // Weight arithmetic
    localparam logic [5:0]  WEIGHT_CLAMP = 6'd63;
    localparam logic [9:0]  DIST_BASE    = 10'd255;
    localparam logic [15:0] ROUND_HALF   = 16'h0080;

endpackage

// File: design/rgb_pair_support_weight_stream.sv
// Channel   Dir  Handshake          Payload
// s_        in   s_tvalid/s_tready  s_tdata[23:0] = {blue, green, red}
// m_        out  m_tvalid/m_tready  m_tdata[27:0] = {row, column, weight}
// apb       in   psel/penable       registers at 0x0 width, 0x4 height, 0x8 distance,
//                                   0xC direction
//
// One pixel per cycle sustained while m_tready holds; after its pixel is accepted a result
// passes the store read, difference stage and multiply stage into the output register.
// The pixel delay store is one synchronous RAM with one write and one read port;
// the write of the current pixel and the read of its partner share the accept cycle.
// Reset clears counters, pointer and registers; the store is not cleared.
// Each stage moves on when the one after it is empty or moving, so an empty slot
// absorbs a stall on m_ and s_tready drops only when the whole pipe is full.
module rgb_pair_support_weight_stream #(
    parameter int MAX_WIDTH    = rpsw_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT   = rpsw_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_DISTANCE = rpsw_pkg::DEF_MAX_DISTANCE
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [rpsw_pkg::S_DATA_W-1:0] s_tdata,   // red, green, blue
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [rpsw_pkg::M_DATA_W-1:0] m_tdata,   // weight, column, row, zero pad
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rpsw_pkg::ADDR_W-1:0]   paddr,
    input  logic [rpsw_pkg::CFG_W-1:0]    pwdata,
    output logic [rpsw_pkg::CFG_W-1:0]    prdata,
    output logic                          pready
);
    import rpsw_pkg::*;

    localparam int SD    = MAX_WIDTH * MAX_DISTANCE;
    localparam int PW    = $clog2(SD);
    localparam int BW    = $clog2(SD + 1);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int DW    = $clog2(MAX_DISTANCE + 1);
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RW    = $clog2(MAX_HEIGHT);
    localparam int CMP_W = ((RW > CW) ? ((RW > DW) ? RW : DW) : ((CW > DW) ? CW : DW)) + 1;
    localparam int AW    = PW + 2;

    // ---------------- configuration ----------------
    logic [CFG_WIDTH_W-1:0]  width_reg;
    logic [CFG_HEIGHT_W-1:0] height_reg;
    logic [CFG_DIST_W-1:0]   distance_reg;
    logic                    direction_reg;
    reg_idx_t                cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = reg_idx_t'(paddr[3:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg     <= RST_WIDTH;
            height_reg    <= RST_HEIGHT;
            distance_reg  <= RST_DISTANCE;
            direction_reg <= DIR_VERTICAL;
        end else if (psel && penable && pwrite && pready) begin
            case (cfg_idx)
                REG_WIDTH:     width_reg     <= pwdata[CFG_WIDTH_W-1:0];
                REG_HEIGHT:    height_reg    <= pwdata[CFG_HEIGHT_W-1:0];
                REG_DISTANCE:  distance_reg  <= pwdata[CFG_DIST_W-1:0];
                REG_DIRECTION: direction_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_WIDTH:     prdata = CFG_W'(width_reg);
            REG_HEIGHT:    prdata = CFG_W'(height_reg);
            REG_DISTANCE:  prdata = CFG_W'(distance_reg);
            REG_DIRECTION: prdata = CFG_W'(direction_reg);
            default:       prdata = '0;
        endcase
    end

    // Effective limits
    logic [WW-1:0] w_eff;
    logic [HW-1:0] h_eff;
    logic [DW-1:0] d_eff;

    always_comb begin
        if (width_reg == '0)
            w_eff = WW'(1);
        else if (32'(width_reg) > MAX_WIDTH)
            w_eff = WW'(MAX_WIDTH);
        else
            w_eff = WW'(width_reg);
        if (height_reg == '0)
            h_eff = HW'(1);
        else if (32'(height_reg) > MAX_HEIGHT)
            h_eff = HW'(MAX_HEIGHT);
        else
            h_eff = HW'(height_reg);
        if (32'(distance_reg) > MAX_DISTANCE)
            d_eff = DW'(MAX_DISTANCE);
        else
            d_eff = DW'(distance_reg);
    end

    // ---------------- pipeline handshake ----------------
    logic s1_valid_reg, s2_valid_reg, out_valid_reg;
    logic out_en, s2_en, s1_en, accept;

    assign out_en   = !out_valid_reg || m_tready;
    assign s2_en    = !s2_valid_reg || out_en;
    assign s1_en    = !s1_valid_reg || s2_en;
    assign s_tready = s1_en;
    assign accept   = s_tvalid && s_tready;

    // ---------------- stage 0: address, counters ----------------
    logic [PW-1:0]      ptr_reg, ptr_next;
    logic [CW-1:0]      col_reg;
    logic [RW-1:0]      row_reg;
    logic [DW+WW-1:0]   back_prod;
    logic [BW-1:0]      back;
    logic [AW-1:0]      addr_diff;
    logic [PW-1:0]      raddr;
    logic [CMP_W-1:0]   col_x, row_x, d_x, col_diff, row_diff;
    logic               emit;
    logic [COL_W-1:0]   col_out;
    logic [ROW_W-1:0]   row_out;
    logic [7:0]         k_val;

    assign back_prod = {{WW{1'b0}}, d_eff} * {{DW{1'b0}}, w_eff};
    assign back      = (direction_reg == DIR_VERTICAL) ? BW'(back_prod) : BW'(d_eff);
    assign addr_diff = AW'(ptr_reg) - AW'(back);
    assign raddr     = addr_diff[AW-1] ? PW'(addr_diff + AW'(SD)) : PW'(addr_diff);
    assign ptr_next  = (32'(ptr_reg) == SD - 1) ? '0 : ptr_reg + PW'(1);

    assign col_x    = CMP_W'(col_reg);
    assign row_x    = CMP_W'(row_reg);
    assign d_x      = CMP_W'(d_eff);
    assign col_diff = col_x - d_x;
    assign row_diff = row_x - d_x;
    assign k_val    = 8'(DIST_BASE - (10'(d_eff) << 2));

    always_comb begin
        if (direction_reg == DIR_VERTICAL) begin
            emit    = row_x >= d_x;
            col_out = COL_W'(col_reg);
            row_out = ROW_W'(row_diff);
        end else begin
            emit    = col_x >= d_x;
            col_out = COL_W'(col_diff);
            row_out = ROW_W'(row_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg <= '0;
            col_reg <= '0;
            row_reg <= '0;
        end else if (accept) begin
            ptr_reg <= ptr_next;
            if (32'(col_reg) + 1 >= 32'(w_eff)) begin
                col_reg <= '0;
                row_reg <= (32'(row_reg) + 1 >= 32'(h_eff)) ? '0 : row_reg + RW'(1);
            end else begin
                col_reg <= col_reg + CW'(1);
            end
        end
    end

    // ---------------- pixel delay store ----------------
    logic [PIX_W-1:0] store_mem [SD];
    logic [PIX_W-1:0] rd_reg;

    // Read-before-write: a partner at the write slot itself returns the old pixel
    always_ff @(posedge aclk) begin
        if (accept)
            store_mem[ptr_reg] <= s_tdata[PIX_W-1:0];
        if (s1_en)
            rd_reg <= store_mem[raddr];
    end

    // ---------------- stage 1: store data ----------------
    logic [PIX_W-1:0] s1_cur_reg;
    logic             s1_self_reg, s1_round_reg;
    logic [7:0]       s1_k_reg;
    logic [COL_W-1:0] s1_col_reg;
    logic [ROW_W-1:0] s1_row_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn)
            s1_valid_reg <= 1'b0;
        else if (s1_en)
            s1_valid_reg <= accept && emit;
    end

    always_ff @(posedge aclk) begin
        if (s1_en) begin
            s1_cur_reg   <= s_tdata[PIX_W-1:0];
            s1_self_reg  <= d_eff == '0;
            s1_round_reg <= direction_reg == DIR_VERTICAL;
            s1_k_reg     <= k_val;
            s1_col_reg   <= col_out;
            s1_row_reg   <= row_out;
        end
    end

    // ---------------- stage 2: absolute differences ----------------
    logic [PIX_W-1:0] prev_pix;
    logic [7:0]       ad_r, ad_g, ad_b;
    logic [9:0]       sad;
    logic [5:0]       sad_clamp;
    logic [7:0]       inv4;

    function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
        abs_diff = (a > b) ? a - b : b - a;
    endfunction

    assign prev_pix  = s1_self_reg ? s1_cur_reg : rd_reg;
    assign ad_r      = abs_diff(prev_pix[7:0],   s1_cur_reg[7:0]);
    assign ad_g      = abs_diff(prev_pix[15:8],  s1_cur_reg[15:8]);
    assign ad_b      = abs_diff(prev_pix[23:16], s1_cur_reg[23:16]);
    assign sad       = 10'(ad_r) + 10'(ad_g) + 10'(ad_b);
    assign sad_clamp = (sad > 10'(WEIGHT_CLAMP)) ? WEIGHT_CLAMP : sad[5:0];
    assign inv4      = {WEIGHT_CLAMP - sad_clamp, 2'b00};

    logic [7:0]       s2_inv_reg;
    logic             s2_round_reg;
    logic [7:0]       s2_k_reg;
    logic [COL_W-1:0] s2_col_reg;
    logic [ROW_W-1:0] s2_row_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn)
            s2_valid_reg <= 1'b0;
        else if (s2_en)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (s2_en) begin
            s2_inv_reg   <= inv4;
            s2_round_reg <= s1_round_reg;
            s2_k_reg     <= s1_k_reg;
            s2_col_reg   <= s1_col_reg;
            s2_row_reg   <= s1_row_reg;
        end
    end

    // ---------------- stage 3: scale into output register ----------------
    logic [15:0]         scaled;
    logic [WEIGHT_W-1:0] weight_reg;
    logic [COL_W-1:0]    col_o_reg;
    logic [ROW_W-1:0]    row_o_reg;

    // Keep 16 bits; weight is bits 15:10 after the rounding add
    assign scaled = 16'({8'd0, s2_inv_reg} * {8'd0, s2_k_reg})
                  + (s2_round_reg ? ROUND_HALF : 16'd0);

    always_ff @(posedge aclk) begin
        if (!aresetn)
            out_valid_reg <= 1'b0;
        else if (out_en)
            out_valid_reg <= s2_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (out_en) begin
            weight_reg <= scaled[15:10];
            col_o_reg  <= s2_col_reg;
            row_o_reg  <= s2_row_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_DATA_W - WEIGHT_W - COL_W - ROW_W){1'b0}},
                       row_o_reg, col_o_reg, weight_reg};

endmodule

// File: tb/sv/rgb_pair_support_weight_stream_tb.sv
`timescale 1ns / 1ps

module rgb_pair_support_weight_stream_tb;
    import rpsw_pkg::*;

    localparam int STORE_DEPTH = DEF_MAX_WIDTH * DEF_MAX_DISTANCE;
    localparam int HOLD_CYCLES = 200;

    typedef struct {
        logic [WEIGHT_W-1:0] weight;
        logic [COL_W-1:0]    column;
        logic [ROW_W-1:0]    row;
    } support_weight_t;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;     // red, green, blue
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;           // weight, column, row, zero pad
    logic                psel     = 1'b0;
    logic                penable  = 1'b0;
    logic                pwrite   = 1'b0;
    logic [ADDR_W-1:0]   paddr    = '0;
    logic [CFG_W-1:0]    pwdata   = '0;
    logic [CFG_W-1:0]    prdata;
    logic                pready;

    // register shadow
    logic [CFG_WIDTH_W-1:0]  cfg_width  = RST_WIDTH;
    logic [CFG_HEIGHT_W-1:0] cfg_height = RST_HEIGHT;
    logic [CFG_DIST_W-1:0]   cfg_dist   = RST_DISTANCE;
    logic                    cfg_dir    = DIR_VERTICAL;

    // predictor state
    logic [PIX_W-1:0] pix_store [0:STORE_DEPTH-1];
    logic [13:0]      wr_ptr  = '0;
    int unsigned      col_cnt = 0;
    int unsigned      row_cnt = 0;

    logic [PIX_W-1:0] pending_pixels[$];
    logic [PIX_W-1:0] sent_hist[$];
    support_weight_t  expected_weights[$];

    bit failed     = 1'b0;
    bit idle_on    = 1'b1;
    bit hold_req   = 1'b0;
    bit hold_taken = 1'b0;

    rgb_pair_support_weight_stream dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
        if (v == 0)
            return 1;
        return (v > hi) ? hi : v;
    endfunction

    function automatic logic [WEIGHT_W-1:0] support_weight(logic [PIX_W-1:0] a,
                                                           logic [PIX_W-1:0] b,
                                                           int unsigned delta,
                                                           bit rounding);
        int unsigned sad;
        int unsigned t;
        int          x;
        int          y;
        sad = 0;
        for (int c = 0; c < 3; c++) begin
            x = a[c*CHAN_W +: CHAN_W];
            y = b[c*CHAN_W +: CHAN_W];
            sad += (x > y) ? x - y : y - x;
        end
        t = (sad > WEIGHT_CLAMP) ? WEIGHT_CLAMP : sad;
        t = (WEIGHT_CLAMP - t) * 4;
        t = t * (DIST_BASE - 4 * delta) + (rounding ? ROUND_HALF : 0);
        t = (t & 32'hFFFF) >> 8;
        return WEIGHT_W'(t >> 2);
    endfunction

    // advance the pixel model by one accepted pixel
    task automatic predict_pixel(input logic [PIX_W-1:0] cur);
        int unsigned     w;
        int unsigned     h;
        int unsigned     d;
        logic [13:0]     idx;
        logic [PIX_W-1:0] partner;
        support_weight_t e;
        bit              hit;
        w = clamp_dim(cfg_width, DEF_MAX_WIDTH);
        h = clamp_dim(cfg_height, DEF_MAX_HEIGHT);
        d = (cfg_dist > DEF_MAX_DISTANCE) ? DEF_MAX_DISTANCE : cfg_dist;
        hit = 1'b0;
        if (cfg_dir == DIR_VERTICAL) begin
            if (row_cnt >= d) begin
                hit = 1'b1;
                idx = wr_ptr - 14'(d * w);
                e.column = COL_W'(col_cnt);
                e.row = ROW_W'(row_cnt - d);
            end
        end else if (col_cnt >= d) begin
            hit = 1'b1;
            idx = wr_ptr - 14'(d);
            e.column = COL_W'(col_cnt - d);
            e.row = ROW_W'(row_cnt);
        end
        if (hit) begin
            partner = (d == 0) ? cur : pix_store[idx];
            e.weight = support_weight(partner, cur, d, cfg_dir == DIR_VERTICAL);
            expected_weights.push_back(e);
        end
        pix_store[wr_ptr] = cur;
        wr_ptr++;
        if (col_cnt + 1 >= w) begin
            col_cnt = 0;
            row_cnt = (row_cnt + 1 >= h) ? 0 : row_cnt + 1;
        end else begin
            col_cnt++;
        end
    endtask

    always @(posedge aclk) begin : pixel_driver
        int tx_gap;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            tx_gap = 0;
        end else begin
            if (s_tvalid && s_tready)
                predict_pixel(s_tdata);
            if (!s_tvalid || s_tready) begin
                if (tx_gap != 0) begin
                    tx_gap--;
                    s_tvalid <= 1'b0;
                end else if (idle_on && pending_pixels.size() != 0 &&
                             $urandom_range(0, 5) == 0) begin
                    tx_gap = $urandom_range(0, 11);
                    s_tvalid <= 1'b0;
                end else if (pending_pixels.size() != 0) begin
                    s_tdata <= pending_pixels.pop_front();
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin : weight_monitor
        support_weight_t e;
        int rx_gap;
        int hold_left;
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_gap = 0;
            hold_left = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_weights.size() == 0) begin
                    $error("unexpected transaction: m_tdata = %h", m_tdata);
                    failed = 1'b1;
                end else begin
                    e = expected_weights.pop_front();
                    if (m_tdata[WEIGHT_W-1:0] !== e.weight) begin
                        $error("weight: expected %0d, actual %0d", e.weight,
                               m_tdata[WEIGHT_W-1:0]);
                        failed = 1'b1;
                    end
                    if (m_tdata[WEIGHT_W +: COL_W] !== e.column) begin
                        $error("column: expected %0d, actual %0d", e.column,
                               m_tdata[WEIGHT_W +: COL_W]);
                        failed = 1'b1;
                    end
                    if (m_tdata[WEIGHT_W+COL_W +: ROW_W] !== e.row) begin
                        $error("row: expected %0d, actual %0d", e.row,
                               m_tdata[WEIGHT_W+COL_W +: ROW_W]);
                        failed = 1'b1;
                    end
                end
            end
            // long back-pressure so the pipe fills and s_tready drops
            if (hold_left != 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                m_tready <= 1'b0;
            end else if (rx_gap != 0) begin
                rx_gap--;
                m_tready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                rx_gap = $urandom_range(0, 11);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

    task automatic reg_write(input reg_idx_t idx, input int unsigned value);
        int fw;
        case (idx)
            REG_WIDTH:    fw = CFG_WIDTH_W;
            REG_HEIGHT:   fw = CFG_HEIGHT_W;
            REG_DISTANCE: fw = CFG_DIST_W;
            default:      fw = 1;
        endcase
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        // junk above the field must be dropped by the register
        pwdata <= value | ($urandom() << fw);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_WIDTH:    cfg_width = CFG_WIDTH_W'(value);
            REG_HEIGHT:   cfg_height = CFG_HEIGHT_W'(value);
            REG_DISTANCE: cfg_dist = CFG_DIST_W'(value);
            default:      cfg_dir = value[0];
        endcase
    endtask

    task automatic wait_drained();
        while (pending_pixels.size() != 0 || s_tvalid || expected_weights.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic push_pixel(input logic [PIX_W-1:0] px);
        pending_pixels.push_back(px);
        sent_hist.push_back(px);
    endtask

    // mostly a noisy copy of the partner pixel so weights spread over the range
    function automatic logic [PIX_W-1:0] next_pixel(int unsigned offset);
        logic [PIX_W-1:0] px;
        logic [PIX_W-1:0] base;
        int spread;
        int v;
        if (offset == 0 || sent_hist.size() < offset || $urandom_range(0, 9) == 0) begin
            for (int c = 0; c < 3; c++)
                px[c*CHAN_W +: CHAN_W] = ($urandom_range(0, 3) == 0) ?
                    {CHAN_W{$urandom_range(0, 1) == 1}} : CHAN_W'($urandom());
            return px;
        end
        base = sent_hist[sent_hist.size() - offset];
        case ($urandom_range(0, 3))
            0:       spread = 0;
            1:       spread = 3;
            2:       spread = 12;
            default: spread = 40;
        endcase
        for (int c = 0; c < 3; c++) begin
            v = int'(base[c*CHAN_W +: CHAN_W]) + int'($urandom_range(0, 2 * spread)) - spread;
            v = (v < 0) ? 0 : (v > 255) ? 255 : v;
            px[c*CHAN_W +: CHAN_W] = CHAN_W'(v);
        end
        return px;
    endfunction

    task automatic queue_pixels(input int n, input int unsigned offset);
        repeat (n) push_pixel(next_pixel(offset));
    endtask

    // one pixel at 1x1, distance 0 brings the counters back to zero
    task automatic start_phase(input int unsigned w, input int unsigned h,
                               input int unsigned d, input logic dir);
        wait_drained();
        reg_write(REG_WIDTH, 1);
        reg_write(REG_HEIGHT, 1);
        reg_write(REG_DISTANCE, 0);
        push_pixel(PIX_W'($urandom()));
        wait_drained();
        reg_write(REG_WIDTH, w);
        reg_write(REG_HEIGHT, h);
        reg_write(REG_DISTANCE, d);
        reg_write(REG_DIRECTION, dir);
    endtask

    initial begin : stimulus
        logic [PIX_W-1:0] horiz_px [16] = '{
            24'h000000, 24'h000000, 24'hFFFFFF, 24'hFFFFFF,
            24'hFFFFFE, 24'hFFFEFE, 24'hFEFEFE, 24'hC1FEFE,
            24'hC0FEFE, 24'h00FEFE, 24'h3F0000, 24'h000000,
            24'h000000, 24'h800000, 24'h80001F, 24'hAA5533};
        logic [PIX_W-1:0] self_px [4] = '{24'h000000, 24'hFFFFFF, 24'h123456, 24'hABCDEF};
        logic [PIX_W-1:0] vert_px [4] = '{24'h000000, 24'hFFFFFF, 24'h000001, 24'hFFFFFF};
        int unsigned w;
        int unsigned h;
        int unsigned d;
        logic        dir;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // registers at reset values: 640 wide, vertical, distance 1
        queue_pixels(660, 640);

        start_phase(16, 1, 1, DIR_HORIZONTAL);
        foreach (horiz_px[i]) push_pixel(horiz_px[i]);
        // zero distance pairs each pixel with itself
        start_phase(2, 2, 0, DIR_VERTICAL);
        foreach (self_px[i]) push_pixel(self_px[i]);
        start_phase(2, 2, 1, DIR_VERTICAL);
        foreach (vert_px[i]) push_pixel(vert_px[i]);

        start_phase(8, 6, 1, DIR_VERTICAL);
        queue_pixels(96, 8);
        start_phase(8, 6, 1, DIR_HORIZONTAL);
        queue_pixels(96, 1);
        start_phase(5, 20, 16, DIR_VERTICAL);
        queue_pixels(120, 80);
        start_phase(20, 3, 16, DIR_HORIZONTAL);
        queue_pixels(100, 16);
        // oversize height and width, oversize distance
        start_phase(1, 8191, 16, DIR_VERTICAL);
        queue_pixels(60, 16);
        start_phase(2047, 1, 31, DIR_HORIZONTAL);
        queue_pixels(100, 16);
        // zero width and height act as 1; every pixel gives a result
        idle_on = 1'b1;
        start_phase(0, 0, 0, DIR_VERTICAL);
        queue_pixels(40, 0);
        hold_req = 1'b1;

        repeat (4) begin
            w = $urandom_range(1, 16);
            h = $urandom_range(1, 8);
            d = ($urandom_range(0, 5) == 0) ? DEF_MAX_DISTANCE : $urandom_range(0, 4);
            dir = $urandom_range(0, 1) ? DIR_HORIZONTAL : DIR_VERTICAL;
            idle_on = ($urandom_range(0, 3) != 0);
            start_phase(w, h, d, dir);
            queue_pixels(w * h * $urandom_range(1, 2), (dir == DIR_VERTICAL) ? d * w : d);
        end

        idle_on = 1'b0;
        start_phase(12, 4, 3, DIR_VERTICAL);
        queue_pixels(96, 36);
        wait_drained();

        if (expected_weights.size() != 0) begin
            $error("%0d expected transactions never arrived", expected_weights.size());
            failed = 1'b1;
        end
        if (!failed) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
